### src/gbr_pkg.sv
// gbr_pkg: shared constants, register codes and reset values for the
// renormalized gaussian blur. No dependencies.
`default_nettype none
package gbr_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 4;
  localparam int NUM_TAPS       = 5;
  localparam int QUEUE_DEPTH    = 2;

  localparam int PIX_W        = 8;
  localparam int RGB_W        = 3 * PIX_W;
  localparam int TAP_W        = 16;
  localparam int ROW_W        = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int RADIUS_REG_W = 3;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int TAP_IDX_W    = $clog2(NUM_TAPS);

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = HEIGHT_REG_W'(480);
  localparam logic [RADIUS_REG_W-1:0] RADIUS_RST = RADIUS_REG_W'(1);
  localparam logic [TAP_W-1:0]        TAP0_RST   = TAP_W'(65535);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_BLUR_RADIUS  = 3'd2,
    REG_TAP_WEIGHT_0 = 3'd3,
    REG_TAP_WEIGHT_1 = 3'd4,
    REG_TAP_WEIGHT_2 = 3'd5,
    REG_TAP_WEIGHT_3 = 3'd6,
    REG_TAP_WEIGHT_4 = 3'd7
  } cfg_index_t;

endpackage
`default_nettype wire

### src/gbr_ifs.sv
// gbr_ifs: valid/ready channel interfaces for pixels in, blurred pixels out
// and register writes. Depends on gbr_pkg.
`default_nettype none
interface gbr_pix_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [gbr_pkg::PIX_W-1:0] pixel_red;
  logic [gbr_pkg::PIX_W-1:0] pixel_green;
  logic [gbr_pkg::PIX_W-1:0] pixel_blue;
  modport source (output valid, action, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink (input valid, action, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface gbr_res_if;
  logic                     valid;
  logic                     ready;
  logic [gbr_pkg::PIX_W-1:0] blur_red;
  logic [gbr_pkg::PIX_W-1:0] blur_green;
  logic [gbr_pkg::PIX_W-1:0] blur_blue;
  logic                     frame_end;
  modport source (output valid, blur_red, blur_green, blur_blue, frame_end, input ready);
  modport sink (input valid, blur_red, blur_green, blur_blue, frame_end, output ready);
endinterface

interface gbr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gbr_pkg::CFG_INDEX_W-1:0] index;
  logic [gbr_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/gbr_line_store.sv
// gbr_line_store: ring of pixel rows, one write and one registered read port.
// Depends on gbr_pkg.
`default_nettype none
module gbr_line_store #(
  parameter int ADDR_W = 14
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [ADDR_W-1:0]         wr_addr,
  input  wire logic [gbr_pkg::RGB_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0]         rd_addr,
  output      logic [gbr_pkg::RGB_W-1:0] rd_data
);
  import gbr_pkg::*;

  logic [RGB_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### src/gbr_queue.sv
// gbr_queue: small fifo of output jobs between front and back.
// Depends on gbr_pkg.
`default_nettype none
module gbr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             not_empty
);
  import gbr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign full      = (count == CNTW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### src/gbr_front.sv
// gbr_front: takes pixels, tracks input and output positions, writes the line
// store and queues one job per ready output. Depends on gbr_pkg, gbr_ifs.
`default_nettype none
module gbr_front #(
  parameter int MAX_WIDTH  = gbr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = gbr_pkg::MAX_RADIUS_DEF,
  parameter int SLOT_BITS  = 4,
  localparam int COL_BITS  = $clog2(MAX_WIDTH),
  localparam int CW        = $clog2(MAX_WIDTH + 1),
  localparam int RB        = $clog2(MAX_RADIUS + 1),
  localparam int ADDR_W    = SLOT_BITS + COL_BITS,
  localparam int JOB_W     = gbr_pkg::ROW_W + COL_BITS + SLOT_BITS + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  gbr_pix_if.sink                        pixel_in,
  input  wire logic [CW-1:0]             eff_w,
  input  wire logic [gbr_pkg::ROW_W-1:0] eff_h,
  input  wire logic [RB-1:0]             eff_r,
  input  wire logic                      q_full,
  output      logic                      push,
  output      logic [JOB_W-1:0]          push_data,
  output      logic                      wr_en,
  output      logic [ADDR_W-1:0]         wr_addr,
  output      logic [gbr_pkg::RGB_W-1:0] wr_data
);
  import gbr_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_BITS-1:0]  col;
    logic [SLOT_BITS-1:0] base;
    logic                 frame_end;
  } job_t;

  logic [COL_BITS-1:0]  in_col, in_col_next;
  logic [ROW_W-1:0]     in_row, in_row_next;
  logic [COL_BITS-1:0]  out_col, out_col_next;
  logic [ROW_W-1:0]     out_row, out_row_next;
  logic [SLOT_BITS-1:0] base, base_next;

  logic                 accept, bad, rdy, fe;
  logic [COL_BITS-1:0]  c_ic, c_oc;
  logic [ROW_W-1:0]     c_ir, c_or;
  logic [ROW_W:0]       rr;
  logic [CW:0]          rc;
  logic [ROW_W-1:0]     h_m1;
  logic [CW-1:0]        w_m1;
  logic [SLOT_BITS-1:0] slot;
  job_t                 job;

  assign pixel_in.ready = !q_full;
  assign accept = pixel_in.valid && !q_full;
  assign h_m1 = eff_h - 1'b1;
  assign w_m1 = eff_w - 1'b1;

  always_comb begin
    bad = (CW'(in_col) >= eff_w) || (in_row > eff_h) ||
          (in_row == eff_h && in_col != '0) ||
          (CW'(out_col) >= eff_w) || (out_row >= eff_h);
    c_ic = bad ? '0 : in_col;
    c_ir = bad ? '0 : in_row;
    c_oc = bad ? '0 : out_col;
    c_or = bad ? '0 : out_row;

    slot    = base + SLOT_BITS'(c_ir);
    wr_addr = {slot, c_ic};
    wr_data = {pixel_in.pixel_red, pixel_in.pixel_green, pixel_in.pixel_blue};
    wr_en   = 1'b0;

    in_col_next = c_ic;
    in_row_next = c_ir;
    if (accept && !pixel_in.action && c_ir < eff_h) begin
      wr_en = 1'b1;
      if (CW'(c_ic) == w_m1) begin
        in_col_next = '0;
        in_row_next = c_ir + 1'b1;
      end else begin
        in_col_next = c_ic + 1'b1;
      end
    end

    rr = (ROW_W + 1)'(c_or) + (ROW_W + 1)'(eff_r);
    if (rr > (ROW_W + 1)'(h_m1)) begin
      rr = (ROW_W + 1)'(h_m1);
    end
    rc = (CW + 1)'(c_oc) + (CW + 1)'(eff_r);
    if (rc > (CW + 1)'(w_m1)) begin
      rc = (CW + 1)'(w_m1);
    end
    rdy = ((ROW_W + 1)'(in_row_next) > rr) ||
          ((ROW_W + 1)'(in_row_next) == rr && (CW + 1)'(in_col_next) > rc);
    push = accept && rdy;
    fe   = (c_or == h_m1) && (CW'(c_oc) == w_m1);

    job.row       = c_or;
    job.col       = c_oc;
    job.base      = base;
    job.frame_end = fe;
    push_data     = job;

    out_col_next = c_oc;
    out_row_next = c_or;
    base_next    = base;
    if (push) begin
      if (fe) begin
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
        base_next    = base + SLOT_BITS'(eff_h);
      end else if (CW'(c_oc) == w_m1) begin
        out_col_next = '0;
        out_row_next = c_or + 1'b1;
      end else begin
        out_col_next = c_oc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      base    <= '0;
    end else if (accept) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      base    <= base_next;
    end
  end
endmodule
`default_nettype wire

### src/gbr_back.sv
// gbr_back: walks the window of one job through the line store, sums weighted
// taps, divides by the weight sum and drives the result register.
// Depends on gbr_pkg, gbr_ifs.
`default_nettype none
module gbr_back #(
  parameter int MAX_WIDTH  = gbr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = gbr_pkg::MAX_RADIUS_DEF,
  parameter int SLOT_BITS  = 4,
  localparam int COL_BITS  = $clog2(MAX_WIDTH),
  localparam int CW        = $clog2(MAX_WIDTH + 1),
  localparam int RB        = $clog2(MAX_RADIUS + 1),
  localparam int ADDR_W    = SLOT_BITS + COL_BITS,
  localparam int JOB_W     = gbr_pkg::ROW_W + COL_BITS + SLOT_BITS + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      job_valid,
  input  wire logic [JOB_W-1:0]          job_data,
  output      logic                      job_pop,
  input  wire logic [CW-1:0]             eff_w,
  input  wire logic [gbr_pkg::ROW_W-1:0] eff_h,
  input  wire logic [RB-1:0]             eff_r,
  input  wire logic [gbr_pkg::TAP_W-1:0] tap_weight [gbr_pkg::NUM_TAPS],
  output      logic [ADDR_W-1:0]         rd_addr,
  input  wire logic [gbr_pkg::RGB_W-1:0] rd_data,
  gbr_res_if.source                      blur_out
);
  import gbr_pkg::*;

  localparam int OB      = $clog2(2 * MAX_RADIUS + 1);
  localparam int NT_MAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int WT_W    = 2 * TAP_W;
  localparam int SW_W    = WT_W + $clog2(NT_MAX + 1);
  localparam int ACC_W   = SW_W + PIX_W;
  localparam int PR_W    = WT_W + PIX_W;
  localparam int XW      = COL_BITS + 1;
  localparam int YW      = ROW_W + 1;
  localparam int QB      = $clog2(PIX_W);

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_BITS-1:0]  col;
    logic [SLOT_BITS-1:0] base;
    logic                 frame_end;
  } job_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ACC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } back_state_t;

  back_state_t     state;
  job_t            job;
  logic [OB-1:0]   dy_i, dx_i, last_i, ay, ax;
  logic [OB-1:0]   r_o;
  logic [YW-1:0]   y_pos, y;
  logic [XW-1:0]   x_pos, x;
  logic            in_img;
  logic [TAP_W-1:0] ta, tb;

  logic              v1, in1, v2;
  logic [WT_W-1:0]   wt1, wt2;
  logic [PR_W-1:0]   pr, pg, pb;
  logic [SW_W-1:0]   sw;
  logic [ACC_W-1:0]  acc_r, acc_g, acc_b, dvs;
  logic [PIX_W-1:0]  q_r, q_g, q_b;
  logic [QB-1:0]     bit_cnt;
  logic              ge_r, ge_g, ge_b, load_out;

  logic              out_valid;
  logic [PIX_W-1:0]  out_r, out_g, out_b;
  logic              out_fe;

  assign r_o    = OB'(eff_r);
  assign last_i = OB'({eff_r, 1'b0});

  always_comb begin
    y_pos  = YW'(job.row) + YW'(dy_i);
    x_pos  = XW'(job.col) + XW'(dx_i);
    y      = y_pos - YW'(eff_r);
    x      = x_pos - XW'(eff_r);
    in_img = (y_pos >= YW'(eff_r)) && (y < YW'(eff_h)) &&
             (x_pos >= XW'(eff_r)) && (x < XW'(eff_w));
    ay     = (dy_i >= r_o) ? dy_i - r_o : r_o - dy_i;
    ax     = (dx_i >= r_o) ? dx_i - r_o : r_o - dx_i;
    ta     = (32'(ay) < NUM_TAPS) ? tap_weight[TAP_IDX_W'(ay)] : '0;
    tb     = (32'(ax) < NUM_TAPS) ? tap_weight[TAP_IDX_W'(ax)] : '0;
    rd_addr = {job.base + SLOT_BITS'(y), x[COL_BITS-1:0]};
  end

  assign job_pop  = (state == ST_IDLE) && job_valid;
  assign ge_r     = acc_r >= dvs;
  assign ge_g     = acc_g >= dvs;
  assign ge_b     = acc_b >= dvs;
  assign load_out = (state == ST_OUT) && (!out_valid || blur_out.ready);

  // tap pipeline: weight product, then weighted channels
  always_ff @(posedge clk) begin
    wt1 <= in_img ? WT_W'(ta) * WT_W'(tb) : '0;
    in1 <= in_img;
    wt2 <= wt1;
    pr  <= in1 ? PR_W'(wt1) * PR_W'(rd_data[3*PIX_W-1:2*PIX_W]) : '0;
    pg  <= in1 ? PR_W'(wt1) * PR_W'(rd_data[2*PIX_W-1:PIX_W]) : '0;
    pb  <= in1 ? PR_W'(wt1) * PR_W'(rd_data[PIX_W-1:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= (state == ST_ACC);
      v2 <= v1;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (blur_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (dx_i == last_i && dy_i == last_i) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (bit_cnt == '0) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        job   <= job_t'(job_data);
        dy_i  <= '0;
        dx_i  <= '0;
        sw    <= '0;
        acc_r <= '0;
        acc_g <= '0;
        acc_b <= '0;
      end
      ST_ACC: begin
        if (dx_i == last_i) begin
          dx_i <= '0;
          dy_i <= dy_i + 1'b1;
        end else begin
          dx_i <= dx_i + 1'b1;
        end
      end
      ST_DRAIN: begin
        dvs     <= ACC_W'(sw) << (PIX_W - 1);
        bit_cnt <= QB'(PIX_W - 1);
      end
      ST_DIV: begin
        if (ge_r) begin
          acc_r <= acc_r - dvs;
        end
        if (ge_g) begin
          acc_g <= acc_g - dvs;
        end
        if (ge_b) begin
          acc_b <= acc_b - dvs;
        end
        q_r     <= {q_r[PIX_W-2:0], ge_r};
        q_g     <= {q_g[PIX_W-2:0], ge_g};
        q_b     <= {q_b[PIX_W-2:0], ge_b};
        dvs     <= dvs >> 1;
        bit_cnt <= bit_cnt - 1'b1;
      end
      default: begin
      end
    endcase
    if ((state == ST_ACC || state == ST_DRAIN) && v2) begin
      sw    <= sw + SW_W'(wt2);
      acc_r <= acc_r + ACC_W'(pr);
      acc_g <= acc_g + ACC_W'(pg);
      acc_b <= acc_b + ACC_W'(pb);
    end
    if (load_out) begin
      out_r  <= (sw == '0) ? '0 : q_r;
      out_g  <= (sw == '0) ? '0 : q_g;
      out_b  <= (sw == '0) ? '0 : q_b;
      out_fe <= job.frame_end;
    end
  end

  assign blur_out.valid      = out_valid;
  assign blur_out.blur_red   = out_r;
  assign blur_out.blur_green = out_g;
  assign blur_out.blur_blue  = out_b;
  assign blur_out.frame_end  = out_fe;

  a_div_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (!v1 && !v2))
    else $error("division started with taps still in flight");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (state == ST_ACC))
    else $error("job popped without starting the window walk");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || blur_out.ready))
    else $error("result register overwritten before transfer");
endmodule
`default_nettype wire

### src/gaussian_blur_renormalized.sv
// gaussian_blur_renormalized: top level, register file, line store, job queue
// and the front and back halves. Depends on gbr_pkg, gbr_ifs and all gbr_ modules.
//
//   channel    dir   payload                                   transfer when
//   pixel_in   in    action, pixel_red/green/blue              valid && ready
//   blur_out   out   blur_red/green/blue, frame_end            valid && ready
//   cfg_wr     in    index (3 bits), data (16 bits)            valid && ready
//
// pixel_in takes one item per cycle while the two-entry job queue has room.
// each blurred pixel in the back half takes one line store read per window
// tap, then an 8-step restoring divide.
// reset is synchronous; the line store is not cleared and needs no sweep.
// a stalled blur_out holds the back half, which then backs up into pixel_in.
`default_nettype none
module gaussian_blur_renormalized #(
  parameter int MAX_WIDTH  = gbr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = gbr_pkg::MAX_RADIUS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  gbr_pix_if.sink   pixel_in,
  gbr_res_if.source blur_out,
  gbr_cfg_if.sink   cfg_wr
);
  import gbr_pkg::*;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int CW        = $clog2(MAX_WIDTH + 1);
  localparam int RB        = $clog2(MAX_RADIUS + 1);
  localparam int SLOT_BITS = $clog2(2 * MAX_RADIUS + QUEUE_DEPTH + 4);
  localparam int ADDR_W    = SLOT_BITS + COL_BITS;
  localparam int JOB_W     = ROW_W + COL_BITS + SLOT_BITS + 1;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [RADIUS_REG_W-1:0] blur_radius;
  logic [TAP_W-1:0]        tap_weight [NUM_TAPS];

  logic [CW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [RB-1:0]    eff_r;

  logic             q_full, q_push, q_pop, q_not_empty;
  logic [JOB_W-1:0] q_in, q_out;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [RGB_W-1:0] wr_data, rd_data;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      blur_radius  <= RADIUS_RST;
      tap_weight[0] <= TAP0_RST;
      tap_weight[1] <= '0;
      tap_weight[2] <= '0;
      tap_weight[3] <= '0;
      tap_weight[4] <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_index_t'(cfg_wr.index))
        REG_IMAGE_WIDTH:  image_width   <= cfg_wr.data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height  <= cfg_wr.data[HEIGHT_REG_W-1:0];
        REG_BLUR_RADIUS:  blur_radius   <= cfg_wr.data[RADIUS_REG_W-1:0];
        REG_TAP_WEIGHT_0: tap_weight[0] <= cfg_wr.data;
        REG_TAP_WEIGHT_1: tap_weight[1] <= cfg_wr.data;
        REG_TAP_WEIGHT_2: tap_weight[2] <= cfg_wr.data;
        REG_TAP_WEIGHT_3: tap_weight[3] <= cfg_wr.data;
        REG_TAP_WEIGHT_4: tap_weight[4] <= cfg_wr.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      eff_w = CW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(image_width);
    end
    eff_h = (image_height == '0) ? ROW_W'(1) : ROW_W'(image_height);
    eff_r = (32'(blur_radius) > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(blur_radius);
  end

  gbr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS),
    .SLOT_BITS (SLOT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pixel_in (pixel_in),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .eff_r    (eff_r),
    .q_full   (q_full),
    .push     (q_push),
    .push_data(q_in),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  gbr_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .not_empty(q_not_empty)
  );

  gbr_line_store #(
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  gbr_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS),
    .SLOT_BITS (SLOT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_not_empty),
    .job_data  (q_out),
    .job_pop   (q_pop),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .eff_r     (eff_r),
    .tap_weight(tap_weight),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .blur_out  (blur_out)
  );
endmodule
`default_nettype wire

### bench/gaussian_blur_renormalized_tb.sv
// gaussian_blur_renormalized_tb: self-checking bench for the renormalized blur,
// with a line-store predictor, random handshake idling and several register setups.
// Depends on gbr_pkg, gbr_ifs and the gaussian_blur_renormalized RTL.
`default_nettype none
module gaussian_blur_renormalized_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbr_pkg::*;

  localparam int LINE_ROWS = 2 * MAX_RADIUS_DEF + 2;
  localparam int SETTLE = 120;
  localparam int LIMIT = 3000000;

  typedef struct {
    bit       flush;
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
  } pix_item_t;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit       frame_end;
  } blur_pix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gbr_pix_if pix ();
  gbr_res_if res ();
  gbr_cfg_if cfg ();

  gaussian_blur_renormalized dut (
    .clk(clk), .rst(rst), .pixel_in(pix), .blur_out(res), .cfg_wr(cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  bit [23:0] line_mem [0:LINE_ROWS-1][0:MAX_WIDTH_DEF-1];
  int unsigned in_col, in_row, out_col, out_row;
  bit [10:0] reg_width;
  bit [12:0] reg_height;
  bit [2:0]  reg_radius;
  bit [15:0] tap_w [0:NUM_TAPS-1];

  pix_item_t pending_pix[$];
  blur_pix_t expected_blur[$];
  pix_item_t cur_pix;
  int        idle_mode;
  int        hold_left;
  int        fails;
  int        cycle_count;

  function automatic int eff_w();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return reg_width;
  endfunction

  function automatic int eff_h();
    return reg_height == 0 ? 1 : reg_height;
  endfunction

  function automatic int eff_r();
    return reg_radius > MAX_RADIUS_DEF ? MAX_RADIUS_DEF : reg_radius;
  endfunction

  function automatic void blur_step(input pix_item_t it);
    int w, h, r, y, x, lim_r, lim_c;
    longint unsigned wsum, rsum, gsum, bsum, wt;
    bit [23:0] p;
    blur_pix_t o;
    w = eff_w();
    h = eff_h();
    r = eff_r();
    if (in_col >= w || in_row > h || (in_row == h && in_col != 0) ||
        out_col >= w || out_row >= h) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
    if (!it.flush && in_row < h) begin
      line_mem[in_row % LINE_ROWS][in_col] = {it.red, it.green, it.blue};
      in_col++;
      if (in_col == w) begin
        in_col = 0;
        in_row++;
      end
    end
    lim_r = (out_row + r > h - 1) ? h - 1 : out_row + r;
    lim_c = (out_col + r > w - 1) ? w - 1 : out_col + r;
    if (!(in_row > lim_r || (in_row == lim_r && in_col > lim_c))) return;
    wsum = 0; rsum = 0; gsum = 0; bsum = 0;
    for (int dy = -r; dy <= r; dy++) begin
      y = int'(out_row) + dy;
      if (y < 0 || y >= h) continue;
      for (int dx = -r; dx <= r; dx++) begin
        x = int'(out_col) + dx;
        if (x < 0 || x >= w) continue;
        wt = longint'(tap_w[dy < 0 ? -dy : dy]) * longint'(tap_w[dx < 0 ? -dx : dx]);
        p = line_mem[y % LINE_ROWS][x];
        wsum += wt;
        rsum += wt * p[23:16];
        gsum += wt * p[15:8];
        bsum += wt * p[7:0];
      end
    end
    if (wsum == 0) begin
      o.red = 0; o.green = 0; o.blue = 0;
    end else begin
      o.red = 8'(rsum / wsum);
      o.green = 8'(gsum / wsum);
      o.blue = 8'(bsum / wsum);
    end
    if (out_row == h - 1 && out_col == w - 1) begin
      o.frame_end = 1'b1;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else begin
      o.frame_end = 1'b0;
      out_col++;
      if (out_col == w) begin
        out_col = 0;
        out_row++;
      end
    end
    expected_blur.push_back(o);
  endfunction

  function automatic bit idle_now(input bit sender);
    if (idle_mode == 3) return $urandom_range(99) < 11;
    if (idle_mode == 1 && sender) return $urandom_range(99) < 49;
    if (idle_mode == 2 && !sender) return $urandom_range(99) < 49;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    fails++;
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) blur_step(cur_pix);
      if (!pix.valid || pix.ready) begin
        if (pending_pix.size() > 0 && !idle_now(1'b1)) begin
          cur_pix = pending_pix.pop_front();
          pix.valid <= 1'b1;
          pix.action <= cur_pix.flush;
          pix.pixel_red <= cur_pix.red;
          pix.pixel_green <= cur_pix.green;
          pix.pixel_blue <= cur_pix.blue;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    blur_pix_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_blur.size() == 0) begin
          report_mismatch("extra transfer on blur_out", 1, 0);
        end else begin
          want = expected_blur.pop_front();
          if (res.blur_red !== want.red) report_mismatch("blur_red", res.blur_red, want.red);
          if (res.blur_green !== want.green)
            report_mismatch("blur_green", res.blur_green, want.green);
          if (res.blur_blue !== want.blue) report_mismatch("blur_blue", res.blur_blue, want.blue);
          if (res.frame_end !== want.frame_end)
            report_mismatch("frame_end", res.frame_end, want.frame_end);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= !idle_now(1'b0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input cfg_index_t idx, input bit [15:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_IMAGE_WIDTH:  reg_width = d[10:0];
      REG_IMAGE_HEIGHT: reg_height = d[12:0];
      REG_BLUR_RADIUS:  reg_radius = d[2:0];
      REG_TAP_WEIGHT_0: tap_w[0] = d;
      REG_TAP_WEIGHT_1: tap_w[1] = d;
      REG_TAP_WEIGHT_2: tap_w[2] = d;
      REG_TAP_WEIGHT_3: tap_w[3] = d;
      default:          tap_w[4] = d;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_pix.size() > 0 || pix.valid || expected_blur.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic bit [15:0] pick_tap();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'd0;
    if (k == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic void push_item(input bit flush, input int pattern);
    pix_item_t it;
    it.flush = flush;
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    if (pattern == 1) begin
      it.red = 0; it.green = 0; it.blue = 0;
    end else if (pattern == 2) begin
      it.red = 8'hFF; it.green = 8'hFF; it.blue = 8'hFF;
    end
    pending_pix.push_back(it);
  endfunction

  // queue one well-formed frame; position tracking decides how many flushes drain it
  function automatic void queue_frame(input bit directed);
    int w, h, r, n, got, sent, lr, lc, oy, ox;
    w = eff_w();
    h = eff_h();
    r = eff_r();
    n = w * h;
    got = 0;
    sent = 0;
    while (sent < n) begin
      if (got < n) begin
        if (!directed && $urandom_range(9) == 0) begin
          push_item(1'b1, 0);
        end else begin
          push_item(1'b0, directed ? got % 3 : 0);
          got++;
        end
      end else begin
        push_item($urandom_range(9) < 7, 0);
      end
      oy = sent / w;
      ox = sent % w;
      lr = (oy + r > h - 1) ? h - 1 : oy + r;
      lc = (ox + r > w - 1) ? w - 1 : ox + r;
      if (got > lr * w + lc) sent++;
    end
    if ($urandom_range(4) == 0) push_item(1'b1, 0);
  endfunction

  task automatic run_phase(input bit [15:0] wv, input bit [15:0] hv, input bit [15:0] rv,
                           input bit [15:0] t0, input bit [15:0] t1, input bit [15:0] t2,
                           input bit [15:0] t3, input bit [15:0] t4,
                           input int frames, input int mode, input bit directed);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, wv);
    write_reg(REG_IMAGE_HEIGHT, hv);
    write_reg(REG_BLUR_RADIUS, rv);
    write_reg(REG_TAP_WEIGHT_0, t0);
    write_reg(REG_TAP_WEIGHT_1, t1);
    write_reg(REG_TAP_WEIGHT_2, t2);
    write_reg(REG_TAP_WEIGHT_3, t3);
    write_reg(REG_TAP_WEIGHT_4, t4);
    cfg.valid <= 1'b0;
    idle_mode = mode;
    for (int f = 0; f < frames; f++) queue_frame(directed);
  endtask

  function automatic bit [15:0] noisy(input int v, input int bits);
    return 16'(v) | (16'($urandom) & ~((16'd1 << bits) - 16'd1));
  endfunction

  initial begin
    pix.valid = 1'b0;
    pix.action = 1'b0;
    pix.pixel_red = '0;
    pix.pixel_green = '0;
    pix.pixel_blue = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_IMAGE_WIDTH;
    cfg.data = '0;
    fails = 0;
    hold_left = 0;
    cycle_count = 0;
    idle_mode = 0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    reg_width = WIDTH_RST;
    reg_height = HEIGHT_RST;
    reg_radius = RADIUS_RST;
    tap_w[0] = TAP0_RST;
    for (int i = 1; i < NUM_TAPS; i++) tap_w[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_phase(4, 3, 1, 16'hFFFF, 16'hFFFF, 0, 0, 0, 1, 0, 1'b1);
    run_phase(3, 2, 1, 0, 0, 0, 0, 0, 1, 0, 1'b0);
    run_phase(0, 0, 0, 16'hFFFF, 0, 0, 0, 0, 2, 0, 1'b0);
    run_phase(20, 1, 4, pick_tap(), pick_tap(), pick_tap(), pick_tap(), pick_tap(),
              1, 0, 1'b0);
    run_phase(1, 40, 0, 16'h8000, 0, 0, 0, 0, 1, 0, 1'b0);
    run_phase(9, 6, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 1'b0);
    hold_left = 600;
    run_phase(8, 5, 2, pick_tap(), pick_tap(), pick_tap(), pick_tap(), pick_tap(),
              1, 0, 1'b0);
    hold_left = 600;
    for (int ph = 0; ph < 8; ph++) begin
      run_phase(noisy($urandom_range(12), 11), noisy($urandom_range(8), 13),
                noisy($urandom_range(7), 3), pick_tap(), pick_tap(), pick_tap(),
                pick_tap(), pick_tap(), $urandom_range(1, 3), ph % 4, 1'b0);
    end
    wait_drained();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
